FILE: sv/chained_string_hash_table_unit_assert.svh
// Assertion macros for the chained string hash table unit.
// Used by the port checker; depends on signals clk and arst_n in scope.
`ifndef CHAINED_STRING_HASH_TABLE_UNIT_ASSERT_SVH
`define CHAINED_STRING_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CHST_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CHST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/chst_pkg.sv
// Shared types and constants of the chained string hash table unit.
// No dependencies.
package chst_pkg;

	localparam int MAX_BUCKETS = 1024;
	localparam int BUCKET_W    = $clog2(MAX_BUCKETS);
	localparam int TSIZE_W     = BUCKET_W + 1;
	localparam int MAX_ENTRIES = 256;
	localparam int ENTRY_W     = $clog2(MAX_ENTRIES);
	localparam int USED_W      = ENTRY_W + 1;
	localparam int KEY_BYTES   = 20;
	localparam int LEN_W       = $clog2(KEY_BYTES + 2);
	localparam int KEY_W       = KEY_BYTES * 8;
	localparam int HASH_W      = 32;
	localparam int DIVCNT_W    = $clog2(HASH_W);

	localparam logic [7:0] CFG_TABLE_SIZE = 8'd0;
	localparam logic [7:0] CFG_HASH_MULT  = 8'd1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_TOO_LONG  = 2'd3
	} status_t;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef struct packed {
		logic              kind;
		logic              too_long;
		logic [HASH_W-1:0] hash;
		logic [LEN_W-1:0]  len;
		logic [KEY_W-1:0]  key;
	} cmd_t;

	typedef struct packed {
		logic               valid;
		logic [ENTRY_W-1:0] idx;
	} ptr_t;

endpackage

FILE: sv/chained_string_hash_table_unit.sv
// Chained string hash table unit.
// Key bytes enter on the slave stream, tuser is the operation (0 insert, 1 search),
// tlast marks the final byte. One result leaves on the master stream per key.
// The configuration channel writes table_size (index 0) and hash_multiplier (index 1);
// other indexes are ignored. It is always ready; the user must write it only while idle,
// which the block does not enforce. The front end folds each byte into the hash with one
// multiply and stalls while the queue is full or the clear pass runs. Finished keys queue
// (two deep) for the back end, which reduces the hash with a bit-serial modulo, reads the
// bucket head, then inserts at the head or, for a search, reads and compares each chain entry.
// A key that is too long answers in the cycle after it leaves the queue.
// Results sit in an output register; while the receiver stalls, the back end
// holds its next key and the front end keeps taking bytes until the queue fills.
// After reset all 1024 entries of the bucket head memory are cleared, one bucket a cycle;
// no byte is taken during that pass. Configuration returns to 1024 buckets, multiplier 31.
module chained_string_hash_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] key_byte
	input  logic        s_tuser,   // [0] kind
	input  logic        s_tlast,   // key_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [1:0] status, [11:2] bucket_index, [15:12] zero
	output logic        m_tuser,   // [0] op_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [chst_pkg::TSIZE_W-1:0]  tsize_q;
	logic [chst_pkg::HASH_W-1:0]   mult_q;
	logic [chst_pkg::TSIZE_W-1:0]  buckets;
	logic                          push, qfull, qavail, pop, clearing;
	chst_pkg::cmd_t                push_cmd, pop_cmd;
	chst_pkg::status_t             status;
	logic [chst_pkg::BUCKET_W-1:0] bucket;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= chst_pkg::TSIZE_W'(chst_pkg::MAX_BUCKETS);
			mult_q  <= 32'd31;
		end else if (cfg_valid) begin
			if (cfg_index == chst_pkg::CFG_TABLE_SIZE) begin
				tsize_q <= cfg_data[chst_pkg::TSIZE_W-1:0];
			end else if (cfg_index == chst_pkg::CFG_HASH_MULT) begin
				mult_q <= cfg_data;
			end
		end
	end

	always_comb begin
		if (tsize_q == '0) begin
			buckets = chst_pkg::TSIZE_W'(1);
		end else if (tsize_q > chst_pkg::TSIZE_W'(chst_pkg::MAX_BUCKETS)) begin
			buckets = chst_pkg::TSIZE_W'(chst_pkg::MAX_BUCKETS);
		end else begin
			buckets = tsize_q;
		end
	end

	chst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.hash_mult (mult_q),
		.hold      (qfull || clearing),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	chst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (qfull),
		.pop      (pop),
		.avail    (qavail),
		.pop_cmd  (pop_cmd)
	);

	chst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.buckets    (buckets),
		.cmd_avail  (qavail),
		.cmd        (pop_cmd),
		.pop        (pop),
		.clearing   (clearing),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (m_tuser),
		.out_status (status),
		.out_bucket (bucket)
	);

	assign m_tdata = {4'b0000, bucket, status};

endmodule

FILE: sv/chst_front.sv
// Front end: collects key bytes, folds the polynomial hash, emits one command per key.
// Depends on chst_pkg.
module chst_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_kind,
	input  logic [7:0]                 in_byte,
	input  logic                       in_last,
	input  logic [chst_pkg::HASH_W-1:0] hash_mult,
	input  logic                       hold,
	output logic                       push,
	output chst_pkg::cmd_t             push_cmd
);

	logic [chst_pkg::HASH_W-1:0] hash_q, hash_nx;
	logic [chst_pkg::KEY_W-1:0]  buf_q, buf_nx;
	logic [chst_pkg::LEN_W-1:0]  cnt_q, cnt_nx;
	logic                        take;

	assign in_ready = !hold;
	assign take     = in_valid && in_ready;

	always_comb begin
		hash_nx = hash_q * hash_mult + {{(chst_pkg::HASH_W-8){1'b0}}, in_byte};
		buf_nx  = buf_q;
		for (int i = 0; i < chst_pkg::KEY_BYTES; i++) begin
			if (cnt_q == chst_pkg::LEN_W'(i)) begin
				buf_nx[i*8 +: 8] = in_byte;
			end
		end
		if (cnt_q < chst_pkg::LEN_W'(chst_pkg::KEY_BYTES)) begin
			cnt_nx = cnt_q + 1'b1;
		end else begin
			cnt_nx = chst_pkg::LEN_W'(chst_pkg::KEY_BYTES + 1);
		end
	end

	assign push              = take && in_last;
	assign push_cmd.kind     = in_kind;
	assign push_cmd.too_long = cnt_nx > chst_pkg::LEN_W'(chst_pkg::KEY_BYTES);
	assign push_cmd.hash     = hash_nx;
	assign push_cmd.len      = cnt_nx;
	assign push_cmd.key      = buf_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			buf_q  <= '0;
			cnt_q  <= '0;
		end else if (take) begin
			if (in_last) begin
				hash_q <= '0;
				buf_q  <= '0;
				cnt_q  <= '0;
			end else begin
				hash_q <= hash_nx;
				buf_q  <= buf_nx;
				cnt_q  <= cnt_nx;
			end
		end
	end

endmodule

FILE: sv/chst_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on chst_pkg.
module chst_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  chst_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           avail,
	output chst_pkg::cmd_t pop_cmd
);

	chst_pkg::cmd_t slots_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     fill_q;

	assign full    = fill_q == 2'd2;
	assign avail   = fill_q != 2'd0;
	assign pop_cmd = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/chst_back.sv
// Back end: reduces the hash to a bucket, inserts or walks the chain, drives the result.
// Holds the bucket head and entry memories. Depends on chst_pkg.
module chst_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [chst_pkg::TSIZE_W-1:0] buckets,
	input  logic                         cmd_avail,
	input  chst_pkg::cmd_t               cmd,
	output logic                         pop,
	output logic                         clearing,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         out_kind,
	output chst_pkg::status_t            out_status,
	output logic [chst_pkg::BUCKET_W-1:0] out_bucket
);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DIV, S_HEAD_RD, S_HEAD_USE, S_ENT_RD, S_ENT_USE
	} state_t;

	state_t                         state_q;
	chst_pkg::cmd_t                 cmd_q;
	logic [chst_pkg::BUCKET_W-1:0]  clr_q;
	logic [chst_pkg::HASH_W-1:0]    div_q;
	logic [chst_pkg::TSIZE_W-1:0]   rem_q;
	logic [chst_pkg::DIVCNT_W-1:0]  dcnt_q;
	logic [chst_pkg::USED_W-1:0]    used_q;
	logic [chst_pkg::ENTRY_W-1:0]   ent_q;
	chst_pkg::ptr_t                 head_rd_q;
	logic [chst_pkg::KEY_W-1:0]     ekey_q;
	logic [chst_pkg::LEN_W-1:0]     elen_q;
	chst_pkg::ptr_t                 elink_q;
	logic                           ins_now;

	chst_pkg::ptr_t                 heads_mem [chst_pkg::MAX_BUCKETS];
	logic [chst_pkg::KEY_W-1:0]     keys_mem  [chst_pkg::MAX_ENTRIES];
	logic [chst_pkg::LEN_W-1:0]     lens_mem  [chst_pkg::MAX_ENTRIES];
	chst_pkg::ptr_t                 links_mem [chst_pkg::MAX_ENTRIES];

	logic [chst_pkg::TSIZE_W:0]     trial;
	logic [chst_pkg::BUCKET_W-1:0]  bucket;

	assign trial    = {rem_q, div_q[chst_pkg::HASH_W-1]};
	assign bucket   = rem_q[chst_pkg::BUCKET_W-1:0];
	assign clearing = state_q == S_CLEAR;
	assign pop      = state_q == S_IDLE && cmd_avail && !out_valid;
	assign ins_now  = state_q == S_HEAD_USE && cmd_q.kind == chst_pkg::KIND_INSERT
		&& !used_q[chst_pkg::ENTRY_W];

	// Memory ports: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			heads_mem[clr_q] <= '0;
		end else if (ins_now) begin
			heads_mem[bucket] <= '{valid: 1'b1, idx: used_q[chst_pkg::ENTRY_W-1:0]};
		end
		if (state_q == S_HEAD_RD) begin
			head_rd_q <= heads_mem[bucket];
		end
	end

	always_ff @(posedge clk) begin
		if (ins_now) begin
			keys_mem[used_q[chst_pkg::ENTRY_W-1:0]]  <= cmd_q.key;
			lens_mem[used_q[chst_pkg::ENTRY_W-1:0]]  <= cmd_q.len;
			links_mem[used_q[chst_pkg::ENTRY_W-1:0]] <= head_rd_q;
		end
		if (state_q == S_ENT_RD) begin
			ekey_q  <= keys_mem[ent_q];
			elen_q  <= lens_mem[ent_q];
			elink_q <= links_mem[ent_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			div_q      <= '0;
			rem_q      <= '0;
			dcnt_q     <= '0;
			used_q     <= '0;
			ent_q      <= '0;
			out_valid  <= 1'b0;
			out_kind   <= 1'b0;
			out_status <= chst_pkg::ST_OK;
			out_bucket <= '0;
		end else begin
			// A new result is only issued while the output register is empty.
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						if (cmd.too_long) begin
							out_valid  <= 1'b1;
							out_kind   <= cmd.kind;
							out_status <= chst_pkg::ST_TOO_LONG;
							out_bucket <= '0;
						end else begin
							div_q   <= cmd.hash;
							rem_q   <= '0;
							dcnt_q  <= '0;
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					// Restoring division, one quotient bit per cycle.
					if (trial >= {1'b0, buckets}) begin
						rem_q <= chst_pkg::TSIZE_W'(trial - {1'b0, buckets});
					end else begin
						rem_q <= trial[chst_pkg::TSIZE_W-1:0];
					end
					div_q  <= {div_q[chst_pkg::HASH_W-2:0], 1'b0};
					dcnt_q <= dcnt_q + 1'b1;
					if (&dcnt_q) begin
						state_q <= S_HEAD_RD;
					end
				end
				S_HEAD_RD: begin
					state_q <= S_HEAD_USE;
				end
				S_HEAD_USE: begin
					out_kind <= cmd_q.kind;
					if (cmd_q.kind == chst_pkg::KIND_INSERT) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
						if (used_q[chst_pkg::ENTRY_W]) begin
							out_status <= chst_pkg::ST_FULL;
							out_bucket <= '0;
						end else begin
							out_status <= chst_pkg::ST_OK;
							out_bucket <= bucket;
							used_q     <= used_q + 1'b1;
						end
					end else if (head_rd_q.valid) begin
						ent_q   <= head_rd_q.idx;
						state_q <= S_ENT_RD;
					end else begin
						out_valid  <= 1'b1;
						out_status <= chst_pkg::ST_NOT_FOUND;
						out_bucket <= '0;
						state_q    <= S_IDLE;
					end
				end
				S_ENT_RD: begin
					state_q <= S_ENT_USE;
				end
				S_ENT_USE: begin
					// Bytes past the length are zero on both sides, so a full compare is exact.
					if (elen_q == cmd_q.len && ekey_q == cmd_q.key) begin
						out_valid  <= 1'b1;
						out_status <= chst_pkg::ST_OK;
						out_bucket <= bucket;
						state_q    <= S_IDLE;
					end else if (elink_q.valid) begin
						ent_q   <= elink_q.idx;
						state_q <= S_ENT_RD;
					end else begin
						out_valid  <= 1'b1;
						out_status <= chst_pkg::ST_NOT_FOUND;
						out_bucket <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/chst_checker.sv
// Port-level checker for the chained string hash table unit, bound to the top level.
// Depends on chained_string_hash_table_unit_assert.svh and chst_pkg.
`include "chained_string_hash_table_unit_assert.svh"

module chst_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	`CHST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`CHST_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`CHST_ASSERT_IMPL(a_ins_status, m_tvalid && m_tuser == chst_pkg::KIND_INSERT, m_tdata[1:0] != chst_pkg::ST_NOT_FOUND, "insert reported not found")
	`CHST_ASSERT_IMPL(a_srch_status, m_tvalid && m_tuser == chst_pkg::KIND_SEARCH, m_tdata[1:0] != chst_pkg::ST_FULL, "search reported store full")
	`CHST_ASSERT_IMPL(a_miss_bucket, m_tvalid && m_tdata[1:0] != chst_pkg::ST_OK, m_tdata[11:2] == 10'd0, "bucket set on failed operation")

endmodule

bind chained_string_hash_table_unit chst_port_checker u_chst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser)
);
